// File: rtl/core/met_pkg.sv
// Shared constants and types for the Mandelbrot escape-time core.
package met_pkg;

    // Internal fixed point: signed, 28 fraction bits; products carry 56.
    localparam int IFRAC = 28;
    // z stays within +/-8 between escape tests, so 33 signed bits hold it.
    localparam int ZW    = 33;
    localparam int PW    = 2 * ZW;
    localparam int CNT_W = 16;

    localparam int FRAC_BITS_DEF   = 28;
    localparam int COORD_WIDTH_DEF = 32;

    localparam logic [CNT_W-1:0] MAX_ITER_RESET = CNT_W'(256);

    localparam logic signed [ZW-1:0] ONE_Q     = ZW'(64'sd1 <<< IFRAC);
    localparam logic signed [ZW-1:0] QUARTER_Q = ZW'(64'sd1 <<< (IFRAC - 2));

    // |z|^2 > 4 and bulb radius^2 = 1/16, both in the product format.
    localparam logic signed [PW:0] ESC_Q  = (PW+1)'(64'sd1 <<< (2 * IFRAC + 2));
    localparam logic signed [PW:0] BULB_Q = (PW+1)'(64'sd1 <<< (2 * IFRAC - 4));

    typedef struct packed {
        logic signed [ZW-1:0] cr;
        logic signed [ZW-1:0] ci;
        logic                 far;   // a part beyond +/-4
        logic                 mid;   // both parts within +/-2
    } met_start_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
    } met_res_t;

endpackage

// File: rtl/core/mandelbrot_escape_time_core.sv
// Top level: Mandelbrot escape-time core with cardioid and period-2 bulb test.
// Flow: a far point (a part beyond +/-4) goes straight to the result; otherwise, when both parts
//   are within +/-2, the cardioid/bulb test runs first, then z passes on the shared 33x33 multiplier;
//   escape at pass i runs i + 1 passes, the last one ending at the escape test; inside runs max_iterations.
// Throughput: one item at a time; s_tready returns once the result sits in the output
//   register, so a new point is not taken until the last one is done.
// Reset (aresetn low, synchronous): sequencer idle, output empty, max_iterations = 256.
module mandelbrot_escape_time_core #(
    parameter int FRAC_BITS   = met_pkg::FRAC_BITS_DEF,
    parameter int COORD_WIDTH = met_pkg::COORD_WIDTH_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // config: max_iterations
    input  logic                                    cfg_we,
    input  logic [met_pkg::CNT_W-1:0]               cfg_wdata,
    // input items
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]      s_tdata,   // c_real, c_imag
    // result items
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [met_pkg::CNT_W-1:0]               m_tdata    // escape_count
);

    localparam int IFRAC = met_pkg::IFRAC;
    localparam int LSH   = (FRAC_BITS < IFRAC) ? (IFRAC - FRAC_BITS) : 0;
    localparam int RSH   = (FRAC_BITS > IFRAC) ? (FRAC_BITS - IFRAC) : 0;
    // Q.28 view of the input, wide enough for the +/-4 limit compare
    localparam int QW    = (COORD_WIDTH + LSH > 34) ? (COORD_WIDTH + LSH) : 34;

    localparam logic signed [QW-1:0] FOUR_Q  = QW'(64'sd1 <<< (IFRAC + 2));
    localparam logic signed [QW-1:0] NFOUR_Q = -FOUR_Q;
    localparam logic signed [QW-1:0] TWO_Q   = QW'(64'sd1 <<< (IFRAC + 1));
    localparam logic signed [QW-1:0] NTWO_Q  = -TWO_Q;

    logic [met_pkg::CNT_W-1:0] max_iter_reg;

    logic signed [COORD_WIDTH-1:0] cr_raw, ci_raw;
    logic signed [QW-1:0]          qr, qi;

    met_pkg::met_start_t start;
    met_pkg::met_res_t   res;
    logic                start_ready, res_valid, res_ready;

    logic                      m_valid_reg;
    logic [met_pkg::CNT_W-1:0] m_data_reg;

    // config register; the user must write it only while idle, the block does not enforce it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_iter_reg <= met_pkg::MAX_ITER_RESET;
        end else if (cfg_we) begin
            max_iter_reg <= cfg_wdata;
        end
    end

    // unpack and convert to Q.28; right shift is a floor
    assign cr_raw = s_tdata[COORD_WIDTH-1:0];
    assign ci_raw = s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
    assign qr     = (QW'(cr_raw) <<< LSH) >>> RSH;
    assign qi     = (QW'(ci_raw) <<< LSH) >>> RSH;

    // range flags; truncation to the core width is exact whenever iteration happens
    assign start.cr  = met_pkg::ZW'(qr);
    assign start.ci  = met_pkg::ZW'(qi);
    assign start.far = (qr > FOUR_Q) || (qr < NFOUR_Q) || (qi > FOUR_Q) || (qi < NFOUR_Q);
    assign start.mid = (qr <= TWO_Q) && (qr >= NTWO_Q) && (qi <= TWO_Q) && (qi >= NTWO_Q);

    met_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (start),
        .start_valid (s_tvalid),
        .start_ready (start_ready),
        .max_iter    (max_iter_reg),
        .res         (res),
        .res_valid   (res_valid),
        .res_ready   (res_ready)
    );

    assign s_tready = start_ready;

    // output register decouples the result from the sequencer
    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (res_valid && res_ready) begin
            m_data_reg <= res.count;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// File: rtl/core/met_mul.sv
// Shared signed multiplier with registered product.
module met_mul (
    input  logic                           aclk,
    input  logic signed [met_pkg::ZW-1:0]  a,
    input  logic signed [met_pkg::ZW-1:0]  b,
    output logic signed [met_pkg::PW-1:0]  p
);

    logic signed [met_pkg::PW-1:0] p_reg;
    logic signed [met_pkg::PW-1:0] p_next;

    assign p_next = met_pkg::PW'(a) * met_pkg::PW'(b);

    always_ff @(posedge aclk) begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

// File: rtl/core/met_seq.sv
// Sequencer and datapath: cardioid/bulb test and z iteration on one multiplier.
module met_seq (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  met_pkg::met_start_t           start,
    input  logic                          start_valid,
    output logic                          start_ready,
    input  logic [met_pkg::CNT_W-1:0]     max_iter,
    output met_pkg::met_res_t             res,
    output logic                          res_valid,
    input  logic                          res_ready
);

    localparam int ZW = met_pkg::ZW;
    localparam int PW = met_pkg::PW;

    typedef enum logic [11:0] {
        S_IDLE = 12'b0000_0000_0001,
        S_CXX  = 12'b0000_0000_0010,
        S_CYY  = 12'b0000_0000_0100,
        S_CQ   = 12'b0000_0000_1000,
        S_CQQ  = 12'b0000_0001_0000,
        S_CBB  = 12'b0000_0010_0000,
        S_CBE  = 12'b0000_0100_0000,
        S_ZRR  = 12'b0000_1000_0000,
        S_ZII  = 12'b0001_0000_0000,
        S_ZRI  = 12'b0010_0000_0000,
        S_ZUP  = 12'b0100_0000_0000,
        S_DONE = 12'b1000_0000_0000
    } met_state_t;

    met_state_t state_reg, state_next;

    logic signed [ZW-1:0] cr_reg, ci_reg, xs_reg, xp_reg;
    logic signed [ZW-1:0] zr_reg, zi_reg, zr_next, zi_next;
    logic signed [PW-1:0] r2_reg, r2_next, y2_reg, y2_next;
    logic                 card_reg, card_next;
    logic [met_pkg::CNT_W-1:0] cnt_reg, cnt_next, count_reg, count_next;
    logic signed [ZW-1:0] cr_next, ci_next, xs_next, xp_next;

    logic signed [ZW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] prod;

    logic signed [PW:0]   r2x, px, y2x, sum_rp, diff_rp;
    logic signed [ZW-1:0] zr_upd, zi_upd, q_new;
    logic signed [PW-1:0] lim;
    logic                 esc, bulb, card_now;

    met_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (prod)
    );

    // Q.56 helpers around the product register
    assign r2x     = (PW+1)'(r2_reg);
    assign px      = (PW+1)'(prod);
    assign y2x     = (PW+1)'(y2_reg);
    assign sum_rp  = r2x + px;
    assign diff_rp = r2x - px;
    assign esc     = sum_rp > met_pkg::ESC_Q;
    assign zr_upd  = ZW'(diff_rp >>> met_pkg::IFRAC) + cr_reg;
    // floor(2*zr*zi / 2^28) == floor(zr*zi / 2^27)
    assign zi_upd  = ZW'(prod >>> (met_pkg::IFRAC - 1)) + ci_reg;
    assign q_new   = ZW'(sum_rp >>> met_pkg::IFRAC);
    assign lim     = (y2_reg + PW'(3)) >>> 2;
    assign card_now = prod < lim;
    assign bulb    = (px + y2x) < met_pkg::BULB_Q;

    // operand select per step
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_CXX: begin mul_a = xs_reg; mul_b = xs_reg; end
            S_CYY: begin mul_a = ci_reg; mul_b = ci_reg; end
            S_CQQ: begin mul_a = zr_reg; mul_b = zi_reg; end
            S_CBB: begin mul_a = xp_reg; mul_b = xp_reg; end
            S_ZRR: begin mul_a = zr_reg; mul_b = zr_reg; end
            S_ZII: begin mul_a = zi_reg; mul_b = zi_reg; end
            S_ZRI: begin mul_a = zr_reg; mul_b = zi_reg; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        cr_next    = cr_reg;
        ci_next    = ci_reg;
        xs_next    = xs_reg;
        xp_next    = xp_reg;
        zr_next    = zr_reg;
        zi_next    = zi_reg;
        r2_next    = r2_reg;
        y2_next    = y2_reg;
        card_next  = card_reg;
        cnt_next   = cnt_reg;
        count_next = count_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (start_valid) begin
                    cr_next = start.cr;
                    ci_next = start.ci;
                    xs_next = start.cr - met_pkg::QUARTER_Q;
                    xp_next = start.cr + met_pkg::ONE_Q;
                    zr_next = '0;
                    zi_next = '0;
                    cnt_next = '0;
                    if (start.far) begin
                        count_next = (max_iter >= met_pkg::CNT_W'(2)) ?
                                     met_pkg::CNT_W'(1) : '0;
                        state_next = S_DONE;
                    end else if (start.mid) begin
                        state_next = S_CXX;
                    end else if (max_iter == '0) begin
                        count_next = '0;
                        state_next = S_DONE;
                    end else begin
                        state_next = S_ZRR;
                    end
                end
            end
            S_CXX: state_next = S_CYY;
            S_CYY: begin
                r2_next    = prod;               // (cr - 1/4)^2
                state_next = S_CQ;
            end
            S_CQ: begin
                y2_next    = prod;               // ci^2
                zr_next    = q_new;              // q
                zi_next    = q_new + xs_reg;     // q + cr - 1/4
                state_next = S_CQQ;
            end
            S_CQQ: state_next = S_CBB;
            S_CBB: begin
                card_next  = card_now;
                state_next = S_CBE;
            end
            S_CBE: begin
                zr_next  = '0;
                zi_next  = '0;
                cnt_next = '0;
                if (card_reg || bulb || (max_iter == '0)) begin
                    count_next = '0;
                    state_next = S_DONE;
                end else begin
                    state_next = S_ZRR;
                end
            end
            S_ZRR: state_next = S_ZII;
            S_ZII: begin
                r2_next    = prod;               // zr^2
                state_next = S_ZRI;
            end
            S_ZRI: begin
                if (esc) begin
                    count_next = cnt_reg;
                    state_next = S_DONE;
                end else begin
                    zr_next    = zr_upd;         // multiplier already took old zr
                    state_next = S_ZUP;
                end
            end
            S_ZUP: begin
                zi_next = zi_upd;
                if (cnt_reg + met_pkg::CNT_W'(1) == max_iter) begin
                    count_next = '0;
                    state_next = S_DONE;
                end else begin
                    cnt_next   = cnt_reg + met_pkg::CNT_W'(1);
                    state_next = S_ZRR;
                end
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
        cr_reg    <= cr_next;
        ci_reg    <= ci_next;
        xs_reg    <= xs_next;
        xp_reg    <= xp_next;
        zr_reg    <= zr_next;
        zi_reg    <= zi_next;
        r2_reg    <= r2_next;
        y2_reg    <= y2_next;
        card_reg  <= card_next;
        cnt_reg   <= cnt_next;
        count_reg <= count_next;
    end

    assign start_ready = (state_reg == S_IDLE);
    assign res_valid   = (state_reg == S_DONE);
    assign res.count   = count_reg;

    a_start_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE && start_valid) |=> (state_reg != S_IDLE))
        else $error("start did not leave idle");

    a_done_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && !res_ready) |=>
        (state_reg == S_DONE && $stable(count_reg)))
        else $error("result dropped while stalled");

    a_first_pass_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ZRR && cnt_reg == '0) |-> (zr_reg == '0 && zi_reg == '0))
        else $error("first pass without z = 0");

    a_zri_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ZRI) |-> ($past(state_reg) == S_ZII))
        else $error("escape test out of order");

endmodule

// File: tb/mandelbrot_escape_time_core_tb.sv
// Self-checking testbench for the Mandelbrot escape-time core.
`timescale 1ns / 1ps

module mandelbrot_escape_time_core_tb;

    // Q.28 reference points used by the escape-count predictor
    localparam longint ONE_Q28     = 64'sd1 <<< met_pkg::IFRAC;
    localparam longint QUARTER_Q28 = ONE_Q28 >>> 2;
    localparam longint TWO_Q28     = 2 * ONE_Q28;
    localparam longint FOUR_Q28    = 4 * ONE_Q28;
    localparam longint BULB_R2_Q56 = 64'sd1 <<< (2 * met_pkg::IFRAC - 4);
    localparam longint unsigned ESC_Q56 = 64'd4 << (2 * met_pkg::IFRAC);

    // no handshake on either side for this many cycles ends the run;
    // slowest quiet stretch is one inside point at 65535 passes
    localparam int WATCHDOG_LIMIT = 1_100_000;

    // directed points; want is typed in only where it is obvious (reset limit 256)
    typedef struct packed {
        logic [31:0] cr;
        logic [31:0] ci;
        logic        typed;
        logic [15:0] want;
    } point_row_t;

    localparam int ROW_COUNT = 23;
    localparam point_row_t POINT_ROWS [ROW_COUNT] = '{
        '{32'h0000_0000, 32'h0000_0000, 1'b1, 16'd0},  // cardioid center
        '{32'hF000_0000, 32'h0000_0000, 1'b1, 16'd0},  // bulb center (-1)
        '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 16'd1},  // far, both max
        '{32'h8000_0000, 32'h8000_0000, 1'b1, 16'd1},  // far, both min
        '{32'h8000_0000, 32'h0000_0000, 1'b1, 16'd1},  // far real only
        '{32'h0000_0000, 32'h7FFF_FFFF, 1'b1, 16'd1},  // far imag only
        '{32'h4000_0001, 32'h0000_0000, 1'b1, 16'd1},  // one lsb beyond +4
        '{32'h0000_0000, 32'hBFFF_FFFF, 1'b1, 16'd1},  // one lsb beyond -4
        '{32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 16'd1},  // far, alternating bits
        '{32'h4000_0000, 32'h0000_0000, 1'b0, 16'd0},  // exactly +4: iterated
        '{32'hC000_0000, 32'hC000_0000, 1'b0, 16'd0},  // exactly -4,-4
        '{32'h2000_0000, 32'h0000_0000, 1'b0, 16'd0},  // +2: shape tests still run
        '{32'hE000_0000, 32'h0000_0000, 1'b0, 16'd0},  // -2: z sticks at |z|^2 = 4
        '{32'h2000_0001, 32'h0000_0000, 1'b0, 16'd0},  // just past 2: tests skipped
        '{32'h0000_0000, 32'h2000_0001, 1'b0, 16'd0},
        '{32'h0400_0000, 32'h0000_0000, 1'b0, 16'd0},  // cardioid cusp 0.25
        '{32'hF400_0000, 32'h0000_0000, 1'b0, 16'd0},  // cardioid/bulb junction
        '{32'hEC00_0000, 32'h0000_0000, 1'b0, 16'd0},  // bulb left edge
        '{32'hFE00_0000, 32'h0BEB_851F, 1'b0, 16'd0},  // period-3 bulb: full run
        '{32'h0000_0000, 32'h0000_0001, 1'b0, 16'd0},  // tiny imag
        '{32'h0800_0000, 32'hFFFF_FFFF, 1'b0, 16'd0},  // 0.5 - lsb*i: escapes
        '{32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 16'd0},  // -lsb: cardioid
        '{32'h0600_0000, 32'h0600_0000, 1'b0, 16'd0}
    };

    localparam int EDGE_COUNT = 13;
    localparam logic [31:0] EDGE_VALUES [EDGE_COUNT] = '{
        32'h7FFF_FFFF, 32'h8000_0000, 32'h4000_0000, 32'h4000_0001, 32'hC000_0000,
        32'hBFFF_FFFF, 32'h2000_0000, 32'h2000_0001, 32'hE000_0000, 32'hDFFF_FFFF,
        32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF
    };

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [15:0] cfg_wdata = 16'd0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata   = 64'd0;   // [31:0] c_real, [63:32] c_imag
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;             // [15:0] escape_count

    // escape counts still owed by the core, oldest first
    logic [15:0] expected_counts [$];
    logic [15:0] iter_limit = met_pkg::MAX_ITER_RESET;   // mirror of max_iterations
    bit          steady_flow = 1'b0;            // no idling on either side
    int          fail_count = 0;
    int          mismatch_count = 0;
    int          idle_cycles = 0;
    int          m_stall_left = 0;

    mandelbrot_escape_time_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Escape pass for point c under a given pass limit.
    // All arithmetic in Q.28, products Q.56; >>> on signed values is a floor.
    function automatic logic [15:0] escape_pass_of(input logic [31:0] cr_raw,
                                                   input logic [31:0] ci_raw,
                                                   input logic [15:0] limit);
        longint cr, ci, zr, zi, nr, ni, xs, xp, y2, q;
        longint unsigned r2, i2;
        int unsigned pass_no;
        cr = longint'($signed(cr_raw));
        ci = longint'($signed(ci_raw));
        // far point: |c|^2 > 4 already at pass 1
        if (cr > FOUR_Q28 || cr < -FOUR_Q28 || ci > FOUR_Q28 || ci < -FOUR_Q28)
            return (limit >= 16'd2) ? 16'd1 : 16'd0;
        // cardioid and period-2 bulb only checked with both parts within +/-2
        if (cr <= TWO_Q28 && cr >= -TWO_Q28 && ci <= TWO_Q28 && ci >= -TWO_Q28) begin
            xs = cr - QUARTER_Q28;
            y2 = ci * ci;
            q  = (xs * xs + y2) >>> met_pkg::IFRAC;
            if (q * (q + xs) < ((y2 + 3) >>> 2))
                return 16'd0;
            xp = cr + ONE_Q28;
            if (xp * xp + y2 < BULB_R2_Q56)
                return 16'd0;
        end
        zr = 0;
        zi = 0;
        for (pass_no = 0; pass_no < limit; pass_no++) begin
            // squares may reach 2^62 each, so the escape sum is unsigned
            r2 = zr * zr;
            i2 = zi * zi;
            if (r2 + i2 > ESC_Q56)
                return 16'(pass_no);
            nr = ((zr * zr - zi * zi) >>> met_pkg::IFRAC) + cr;
            ni = ((2 * zr * zi) >>> met_pkg::IFRAC) + ci;
            zr = nr;
            zi = ni;
        end
        return 16'd0;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 1;
        if (r < 88) return $urandom_range(2, 4);
        if (r < 97) return $urandom_range(5, 16);
        return $urandom_range(30, 80);
    endfunction

    // Random point. Most land in the +/-2 box where the interesting behavior is;
    // wild mode draws raw 32-bit patterns only (used at the huge pass limit).
    task automatic pick_point(input bit wild, output logic [31:0] cr, output logic [31:0] ci);
        int r;
        r = wild ? 99 : $urandom_range(0, 99);
        if (r < 58) begin
            cr = $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
            ci = $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
        end else if (r < 72) begin
            cr = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
            ci = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
        end else if (r < 82) begin
            // 1/16 grid: lands exactly on shape boundaries
            cr = ($urandom_range(0, 64) - 32) << 24;
            ci = ($urandom_range(0, 64) - 32) << 24;
        end else if (r < 88) begin
            cr = EDGE_VALUES[$urandom_range(0, EDGE_COUNT - 1)];
            ci = ($urandom_range(0, 1) == 0) ? EDGE_VALUES[$urandom_range(0, EDGE_COUNT - 1)]
                                             : $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
        end else begin
            cr = $urandom;
            ci = $urandom;
        end
    endtask

    // Offer one point; the expectation is queued at the accepting edge.
    task automatic send_point(input logic [31:0] cr, input logic [31:0] ci,
                              input logic typed, input logic [15:0] want);
        int gap;
        gap = 0;
        if (!steady_flow && $urandom_range(0, 99) >= 45)
            gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ci, cr};
        do @(posedge aclk); while (!s_tready);
        expected_counts.push_back(typed ? want : escape_pass_of(cr, ci, iter_limit));
    endtask

    // Stop sending and wait until every owed result has come back.
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        while (expected_counts.size() != 0) @(posedge aclk);
    endtask

    // Register write, only with the core idle.
    task automatic set_iteration_limit(input logic [15:0] value);
        wait_for_drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we     <= 1'b0;
        iter_limit  = value;
    endtask

    task automatic send_random(input int count, input bit wild);
        logic [31:0] cr, ci;
        for (int n = 0; n < count; n++) begin
            pick_point(wild, cr, ci);
            send_point(cr, ci, 1'b0, 16'd0);
        end
    endtask

    // Result side back-pressure.
    always @(posedge aclk) begin
        if (m_stall_left > 0) begin
            m_stall_left = m_stall_left - 1;
            m_tready <= 1'b0;
        end else if (!steady_flow && $urandom_range(0, 99) < 30) begin
            m_stall_left = pick_gap() - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Result checker: each accepted item against the oldest expectation.
    always @(posedge aclk) begin
        logic [15:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_counts.size() == 0) begin
                fail_count++;
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected result item, escape_count %0d", $realtime, m_tdata);
            end else begin
                want = expected_counts.pop_front();
                if (m_tdata !== want) begin
                    fail_count++;
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: escape_count expected %0d, got %0d",
                                 $realtime, want, m_tdata);
                end
            end
        end
    end

    // Watchdog on cycles with no handshake on either side.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset limit of 256 passes: directed points, then random ones,
        // with one full drain in the middle
        for (int n = 0; n < ROW_COUNT; n++)
            send_point(POINT_ROWS[n].cr, POINT_ROWS[n].ci, POINT_ROWS[n].typed,
                       POINT_ROWS[n].want);
        send_random(200, 1'b0);
        wait_for_drain();
        send_random(220, 1'b0);

        // smallest limit: every point reads as inside
        set_iteration_limit(16'd1);
        send_random(200, 1'b0);

        // two passes: far points give 1; steady flow on both sides
        set_iteration_limit(16'd2);
        steady_flow = 1'b1;
        send_random(150, 1'b0);
        steady_flow = 1'b0;

        // largest limit: one long inside run, the rest finish quickly
        set_iteration_limit(16'hFFFF);
        send_point(32'hFE00_0000, 32'h0BEB_851F, 1'b0, 16'd0);
        send_point(32'h0800_0000, 32'h0000_0000, 1'b0, 16'd0);
        send_point(32'h4000_0000, 32'h0000_0000, 1'b0, 16'd0);
        send_point(32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 16'd0);
        send_point(32'h0000_0000, 32'h0000_0000, 1'b0, 16'd0);
        send_random(12, 1'b1);

        // assorted mid-size limits
        for (int k = 0; k < 4; k++) begin
            set_iteration_limit(16'($urandom_range(3, 300)));
            send_random(150, 1'b0);
        end

        // back to the reset value, no idling
        set_iteration_limit(met_pkg::MAX_ITER_RESET);
        steady_flow = 1'b1;
        send_random(150, 1'b0);

        wait_for_drain();
        // room for any stray result item to show up
        repeat (50) @(posedge aclk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
